>>> hw/rtl/mip_pkg.sv
// shared constants, types and helpers for the plaquette ising update block
// no dependencies; imported by every module of the block but mip_ram
package mip_pkg;

	// lattice geometry, side must be an even power of two
	localparam int unsigned SIDE   = 64;
	localparam int unsigned ROW_W  = $clog2(SIDE);
	localparam int unsigned HALF_W = ROW_W - 1;
	localparam int unsigned SITES  = SIDE * SIDE;
	localparam int unsigned POS_W  = $clog2(SITES);

	// magnetization is kept modulo 2^SUM_W
	localparam int unsigned SUM_W = 14;

	// boltzmann factors, UQ8.24
	localparam int unsigned FACTOR_W = 32;
	localparam int unsigned FRAC_W   = 24;
	localparam int unsigned PROD_W   = 2 * FACTOR_W;
	localparam logic [FACTOR_W-1:0] ONE_Q24 = FACTOR_W'(1) << FRAC_W;

	// configuration register map
	localparam int unsigned NUM_FACTORS = 8;
	localparam int unsigned FIDX_W      = $clog2(NUM_FACTORS);
	localparam int unsigned CFG_IDX_W   = FIDX_W + 1;
	localparam int unsigned REG_PAIR_PLUS8  = 0;
	localparam int unsigned REG_PAIR_MINUS8 = 3;
	localparam int unsigned REG_PLAQ_PLUS8  = 4;
	localparam int unsigned REG_PLAQ_MINUS8 = 7;

	// position of each energy inside one factor set
	localparam int unsigned F_PLUS8  = 0;
	localparam int unsigned F_PLUS4  = 1;
	localparam int unsigned F_MINUS4 = 2;
	localparam int unsigned F_MINUS8 = 3;

	typedef enum logic {
		ACT_LOAD   = 1'b0,
		ACT_UPDATE = 1'b1
	} action_t;

	typedef logic [FACTOR_W-1:0] factor_t;
	typedef factor_t [3:0] factor_set_t;
	typedef logic [2:0] align_cnt_t;

	// visited spin and its eight neighbors, 1 means +1
	typedef struct packed {
		logic s;
		logic u;
		logic d;
		logic l;
		logic r;
		logic ul;
		logic ur;
		logic dl;
		logic dr;
	} nbhd_t;

	typedef struct packed {
		logic flip;
		logic rnd_needed;
	} accept_t;

	// energy is 4*cnt - 8, cnt counts the terms that agree with the spin
	function automatic factor_t pick_factor(input align_cnt_t cnt, input factor_set_t set);
		factor_t f;
		unique case (cnt)
			3'd4:    f = set[F_PLUS8];
			3'd3:    f = set[F_PLUS4];
			3'd1:    f = set[F_MINUS4];
			3'd0:    f = set[F_MINUS8];
			default: f = ONE_Q24;
		endcase
		return f;
	endfunction

endpackage

>>> hw/rtl/mip_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module mip_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/mip_accept.sv
// energy terms, factor lookup, exact factor product and the flip decision
// depends on mip_pkg
module mip_accept (
	input  mip_pkg::nbhd_t                   nb,
	input  mip_pkg::factor_set_t             pair_set,
	input  mip_pkg::factor_set_t             plaq_set,
	input  logic [mip_pkg::FRAC_W-1:0]       random_fraction,
	output mip_pkg::accept_t                 res
);
	import mip_pkg::*;

	logic [3:0]          pair_agree;
	logic [3:0]          plaq_agree;
	align_cnt_t          pair_cnt;
	align_cnt_t          plaq_cnt;
	factor_t             pair_f;
	factor_t             plaq_f;
	logic [PROD_W-1:0]   prod;
	logic                certain;
	logic [2*FRAC_W-1:0] rnd_scaled;

	always_comb begin
		// pair term agrees when the neighbor equals the spin
		pair_agree[0] = nb.s ~^ nb.u;
		pair_agree[1] = nb.s ~^ nb.d;
		pair_agree[2] = nb.s ~^ nb.l;
		pair_agree[3] = nb.s ~^ nb.r;
		// four-spin term is +1 when it holds an even number of down spins
		plaq_agree[0] = ~(nb.s ^ nb.ul ^ nb.l ^ nb.u);
		plaq_agree[1] = ~(nb.s ^ nb.ur ^ nb.r ^ nb.u);
		plaq_agree[2] = ~(nb.s ^ nb.dl ^ nb.l ^ nb.d);
		plaq_agree[3] = ~(nb.s ^ nb.dr ^ nb.r ^ nb.d);
		pair_cnt = {2'b00, pair_agree[0]} + {2'b00, pair_agree[1]}
			+ {2'b00, pair_agree[2]} + {2'b00, pair_agree[3]};
		plaq_cnt = {2'b00, plaq_agree[0]} + {2'b00, plaq_agree[1]}
			+ {2'b00, plaq_agree[2]} + {2'b00, plaq_agree[3]};
		pair_f = pick_factor(pair_cnt, pair_set);
		plaq_f = pick_factor(plaq_cnt, plaq_set);
		prod = PROD_W'(pair_f) * PROD_W'(plaq_f);
		// product is UQ16.48, at least 1.0 means a certain flip
		certain = |prod[PROD_W-1:2*FRAC_W];
		rnd_scaled = {random_fraction, FRAC_W'(0)};
		res.rnd_needed = ~certain;
		res.flip = certain | (rnd_scaled <= prod[2*FRAC_W-1:0]);
	end

endmodule

>>> hw/rtl/metropolis_ising_plaquette_update.sv
// an accepted item is held in stage 1, then moves to the result register when not stalled
// throughput: one item per cycle while not stalled, set by one registered read of three lattice rows
// reset: factors read 1.0, lattice all down, magnetization -4096, sweep at first site
// after reset all 64 lattice rows are cleared one per cycle, with in_stall high
// configuration writes are taken during that clearing pass as ever
module metropolis_ising_plaquette_update (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mip_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mip_pkg::FACTOR_W-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [mip_pkg::ROW_W-1:0]         site_row,
	input  logic [mip_pkg::ROW_W-1:0]         site_col,
	input  logic                              spin_up,
	input  logic [mip_pkg::FRAC_W-1:0]        random_fraction,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              flipped,
	output logic                              random_needed,
	output logic signed [mip_pkg::SUM_W-1:0]  magnetization,
	output logic                              sweep_done
);
	import mip_pkg::*;

	// configuration
	factor_t [NUM_FACTORS-1:0] factor_q;
	factor_set_t               pair_set;
	factor_set_t               plaq_set;

	// sweep and clearing state
	logic [POS_W-1:0] pos_q;
	logic             clr_busy_q;
	logic [ROW_W-1:0] clr_row_q;
	logic signed [SUM_W-1:0] sum_q;

	// accept side
	logic             in_acc;
	logic             adv;
	logic [1:0]       grp;
	logic [ROW_W-1:0] sweep_row;
	logic [ROW_W-1:0] sweep_col;
	logic [ROW_W-1:0] rd_row;
	logic [ROW_W-1:0] rd_col;

	// stage 1
	logic                valid_s1;
	action_t             action_s1;
	logic [ROW_W-1:0]    row_s1;
	logic [ROW_W-1:0]    col_s1;
	logic                spin_s1;
	logic [FRAC_W-1:0]   rnd_s1;
	logic                done_s1;
	logic [ROW_W-1:0]    rm_s1;
	logic [ROW_W-1:0]    rp_s1;
	logic [ROW_W-1:0]    cm_s1;
	logic [ROW_W-1:0]    cp_s1;

	// lattice rows
	logic [SIDE-1:0]  up_rd;
	logic [SIDE-1:0]  mid_rd;
	logic [SIDE-1:0]  dn_rd;
	logic [SIDE-1:0]  up_row;
	logic [SIDE-1:0]  mid_row;
	logic [SIDE-1:0]  dn_row;
	logic [SIDE-1:0]  new_row;
	logic             wr_en;
	logic [ROW_W-1:0] wr_row;
	logic [SIDE-1:0]  wr_data;
	logic             fwd_vld_q;
	logic [ROW_W-1:0] fwd_row_q;
	logic [SIDE-1:0]  fwd_data_q;

	nbhd_t   nb;
	accept_t acc;
	logic    flip;
	logic    new_bit;
	logic signed [SUM_W-1:0] sum_next;

	// result register
	logic                    out_valid_q;
	logic                    flipped_q;
	logic                    rnd_needed_q;
	logic signed [SUM_W-1:0] mag_q;
	logic                    done_q;

	assign pair_set = factor_q[REG_PAIR_MINUS8:REG_PAIR_PLUS8];
	assign plaq_set = factor_q[REG_PLAQ_MINUS8:REG_PLAQ_PLUS8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_FACTORS; k++) begin
				factor_q[k] <= ONE_Q24;
			end
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_FACTORS))) begin
			factor_q[cfg_index[FIDX_W-1:0]] <= cfg_data;
		end
	end

	// handshake
	assign adv      = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = clr_busy_q | (valid_s1 & ~adv);
	assign in_acc   = in_valid & ~in_stall;

	// sweep position: two sublattice bits, then row-major within the sublattice
	assign grp       = pos_q[POS_W-1 -: 2];
	assign sweep_row = {pos_q[POS_W-3 -: HALF_W], grp[1]};
	assign sweep_col = {pos_q[HALF_W-1:0], grp[0]};
	assign rd_row    = (action == ACT_UPDATE) ? sweep_row : site_row;
	assign rd_col    = (action == ACT_UPDATE) ? sweep_col : site_col;

	mip_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_ram_up (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_row),
		.wdata (wr_data),
		.re    (in_acc),
		.raddr (rd_row - ROW_W'(1)),
		.rdata (up_rd)
	);

	mip_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_ram_mid (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_row),
		.wdata (wr_data),
		.re    (in_acc),
		.raddr (rd_row),
		.rdata (mid_rd)
	);

	mip_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_ram_dn (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_row),
		.wdata (wr_data),
		.re    (in_acc),
		.raddr (rd_row + ROW_W'(1)),
		.rdata (dn_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q    <= '0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
				if (action == ACT_UPDATE) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_s1 <= action_t'(action);
			row_s1    <= rd_row;
			col_s1    <= rd_col;
			spin_s1   <= spin_up;
			rnd_s1    <= random_fraction;
			done_s1   <= (action == ACT_UPDATE) && (&pos_q);
		end
	end

	assign rm_s1 = row_s1 - ROW_W'(1);
	assign rp_s1 = row_s1 + ROW_W'(1);
	assign cm_s1 = col_s1 - ROW_W'(1);
	assign cp_s1 = col_s1 + ROW_W'(1);

	// the row written on the edge of the read is not yet in the ram output
	always_comb begin
		up_row  = (fwd_vld_q && fwd_row_q == rm_s1) ? fwd_data_q : up_rd;
		mid_row = (fwd_vld_q && fwd_row_q == row_s1) ? fwd_data_q : mid_rd;
		dn_row  = (fwd_vld_q && fwd_row_q == rp_s1) ? fwd_data_q : dn_rd;
	end

	always_comb begin
		nb.s  = mid_row[col_s1];
		nb.l  = mid_row[cm_s1];
		nb.r  = mid_row[cp_s1];
		nb.u  = up_row[col_s1];
		nb.ul = up_row[cm_s1];
		nb.ur = up_row[cp_s1];
		nb.d  = dn_row[col_s1];
		nb.dl = dn_row[cm_s1];
		nb.dr = dn_row[cp_s1];
	end

	mip_accept u_accept (
		.nb              (nb),
		.pair_set        (pair_set),
		.plaq_set        (plaq_set),
		.random_fraction (rnd_s1),
		.res             (acc)
	);

	always_comb begin
		flip    = (action_s1 == ACT_UPDATE) & acc.flip;
		new_bit = (action_s1 == ACT_UPDATE) ? (nb.s ^ flip) : spin_s1;
		new_row = mid_row;
		new_row[col_s1] = new_bit;
		if (new_bit == nb.s) begin
			sum_next = sum_q;
		end else if (new_bit) begin
			sum_next = sum_q + SUM_W'(2);
		end else begin
			sum_next = sum_q - SUM_W'(2);
		end
	end

	// clearing pass owns the write port until it ends
	assign wr_en   = clr_busy_q | adv;
	assign wr_row  = clr_busy_q ? clr_row_q : row_s1;
	assign wr_data = clr_busy_q ? '0 : new_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
			fwd_vld_q  <= 1'b0;
			sum_q      <= -SUM_W'(SITES);
		end else begin
			if (clr_busy_q) begin
				clr_row_q <= clr_row_q + ROW_W'(1);
				if (clr_row_q == ROW_W'(SIDE - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (wr_en) begin
				fwd_vld_q <= 1'b1;
			end
			if (adv) begin
				sum_q <= sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_row_q  <= wr_row;
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flipped_q    <= flip;
			rnd_needed_q <= (action_s1 == ACT_UPDATE) & acc.rnd_needed;
			mag_q        <= sum_next;
			done_q       <= done_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign flipped       = flipped_q;
	assign random_needed = rnd_needed_q;
	assign magnetization = mag_q;
	assign sweep_done    = done_q;

endmodule

>>> hw/rtl/mip_checker.sv
// port-level checks for the plaquette ising update block, bound to the top level
// depends on mip_pkg and metropolis_ising_plaquette_update
module mip_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              flipped,
	input logic                              random_needed,
	input logic signed [mip_pkg::SUM_W-1:0]  magnetization,
	input logic                              sweep_done
);
	import mip_pkg::*;

	localparam logic signed [SUM_W-1:0] MAG_MAX = SUM_W'(SITES);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(magnetization) && $stable(flipped)
			&& $stable(random_needed) && $stable(sweep_done))
		else $error("result changed while stalled");

	// out_valid follows every accepted item
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 out_valid)
		else $error("accepted item produced no result");

	// the spin sum of an even site count is even and bounded
	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !magnetization[0] && magnetization <= MAG_MAX
			&& magnetization >= -MAG_MAX)
		else $error("magnetization out of range or odd");

	// lattice clearing keeps the input closed right after reset
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_stall)
		else $error("item taken before the lattice was cleared");

endmodule

bind metropolis_ising_plaquette_update mip_checker u_mip_checker (.*);

>>> dv/metropolis_ising_plaquette_update_tb.sv
`timescale 1ns / 100ps
// testbench for metropolis_ising_plaquette_update: spin loads and sweep updates under several
// factor settings, each result checked against an in-bench lattice and factor model
// depends on mip_pkg and the block rtl only
module metropolis_ising_plaquette_update_tb;
	import mip_pkg::*;

	localparam int unsigned REG_PAIR_PLUS4  = 1;
	localparam int unsigned REG_PAIR_MINUS4 = 2;
	localparam int unsigned REG_PLAQ_PLUS4  = 5;
	localparam int unsigned REG_PLAQ_MINUS4 = 6;
	localparam int unsigned REG_UNMAPPED_LO = NUM_FACTORS;
	localparam int unsigned REG_UNMAPPED_HI = (1 << CFG_IDX_W) - 1;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned HOLD_CYCLES  = 60;
	localparam int unsigned PHASE_ITEMS  = 250;
	localparam int unsigned NUM_PHASES   = 4;
	localparam int unsigned TAIL_ITEMS   = 64;
	localparam logic [PROD_W-1:0] PROD_ONE = PROD_W'(1) << (2 * FRAC_W);
	localparam logic [FRAC_W-1:0] FRAC_MAX  = '1;
	localparam logic [FRAC_W-1:0] FRAC_HALF = FRAC_W'(1) << (FRAC_W - 1);

	typedef struct {
		action_t                 act;
		logic [ROW_W-1:0]        row;
		logic [ROW_W-1:0]        col;
		logic                    up;
		logic [FRAC_W-1:0]       frac;
	} spin_item_t;

	typedef struct {
		logic                    flipped;
		logic                    rnd_needed;
		logic signed [SUM_W-1:0] mag;
		logic                    done;
	} spin_result_t;

	class ising_scoreboard;
		bit lattice [SITES];
		int spin_total;
		int unsigned sweep_pos;
		factor_t factors [NUM_FACTORS];
		spin_result_t pending_results [$];
		int unsigned errors, checked, loads, updates, flips, rnd_decided, sweeps;

		function new();
			foreach (lattice[k]) lattice[k] = 1'b0;
			foreach (factors[k]) factors[k] = ONE_Q24;
			spin_total = -int'(SITES);
			sweep_pos = 0;
			errors = 0;
			checked = 0;
			loads = 0;
			updates = 0;
			flips = 0;
			rnd_decided = 0;
			sweeps = 0;
		endfunction

		function void write_factor(input int unsigned idx, input factor_t data);
			if (idx < NUM_FACTORS)
				factors[idx] = data;
		endfunction

		function int unsigned site_index(input int unsigned row, input int unsigned col);
			return (row % SIDE) * SIDE + (col % SIDE);
		endfunction

		function int spin_of(input int unsigned row, input int unsigned col);
			return lattice[site_index(row, col)] ? 1 : -1;
		endfunction

		// sublattice order: even/even, even/odd, odd/even, odd/odd, row-major in each
		function void site_of_pos(input int unsigned p, output int unsigned row,
				output int unsigned col);
			int unsigned half, quad, grp, q;
			half = SIDE / 2;
			quad = half * half;
			grp = p / quad;
			q = p % quad;
			row = 2 * (q / half) + grp / 2;
			col = 2 * (q % half) + grp % 2;
		endfunction

		function factor_t energy_factor(input int e, input int unsigned base);
			case (e)
				8:       return factors[base + F_PLUS8];
				4:       return factors[base + F_PLUS4];
				-4:      return factors[base + F_MINUS4];
				-8:      return factors[base + F_MINUS8];
				default: return ONE_Q24;
			endcase
		endfunction

		// exact acceptance product for the site that the sweep visits next
		function logic [PROD_W-1:0] site_product();
			int unsigned r, c, rm, rp, cm, cp;
			int s, u, d, l, rt, ul, ur, dl, dr, e1, e2;
			site_of_pos(sweep_pos, r, c);
			rm = r + SIDE - 1;
			rp = r + 1;
			cm = c + SIDE - 1;
			cp = c + 1;
			s  = spin_of(r, c);
			u  = spin_of(rm, c);
			d  = spin_of(rp, c);
			l  = spin_of(r, cm);
			rt = spin_of(r, cp);
			ul = spin_of(rm, cm);
			ur = spin_of(rm, cp);
			dl = spin_of(rp, cm);
			dr = spin_of(rp, cp);
			e1 = 2 * s * (u + d + l + rt);
			e2 = 2 * s * ((ul * l + ur * rt) * u + (dl * l + dr * rt) * d);
			return PROD_W'(energy_factor(e1, REG_PAIR_PLUS8)) *
				PROD_W'(energy_factor(e2, REG_PLAQ_PLUS8));
		endfunction

		function void note_item(input spin_item_t it);
			spin_result_t res;
			int unsigned r, c, idx;
			logic [PROD_W-1:0] prod;
			bit flip;
			res.flipped = 1'b0;
			res.rnd_needed = 1'b0;
			res.done = 1'b0;
			if (it.act == ACT_LOAD) begin
				loads++;
				idx = site_index(it.row, it.col);
				if (lattice[idx] != it.up)
					spin_total += it.up ? 2 : -2;
				lattice[idx] = it.up;
			end else begin
				updates++;
				prod = site_product();
				if (prod >= PROD_ONE) begin
					flip = 1'b1;
				end else begin
					res.rnd_needed = 1'b1;
					rnd_decided++;
					flip = (PROD_W'(it.frac) << FRAC_W) <= prod;
				end
				if (flip) begin
					site_of_pos(sweep_pos, r, c);
					idx = site_index(r, c);
					lattice[idx] = !lattice[idx];
					spin_total += lattice[idx] ? 2 : -2;
					res.flipped = 1'b1;
					flips++;
				end
				if (sweep_pos >= SITES - 1) begin
					sweep_pos = 0;
					res.done = 1'b1;
					sweeps++;
				end else begin
					sweep_pos++;
				end
			end
			res.mag = SUM_W'(spin_total);
			pending_results.push_back(res);
		endfunction

		function void report(input string field, input logic signed [31:0] want,
				input logic signed [31:0] got);
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, field, want, got);
		endfunction

		function void check_result(input spin_result_t got);
			spin_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected item out: flipped %0d magnetization %0d", $time,
					got.flipped, got.mag);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (got.flipped !== want.flipped)
				report("flipped", want.flipped, got.flipped);
			if (got.rnd_needed !== want.rnd_needed)
				report("random_needed", want.rnd_needed, got.rnd_needed);
			if (got.mag !== want.mag)
				report("magnetization", want.mag, got.mag);
			if (got.done !== want.done)
				report("sweep_done", want.done, got.done);
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [FACTOR_W-1:0]     cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic                    action;
	logic [ROW_W-1:0]        site_row;
	logic [ROW_W-1:0]        site_col;
	logic                    spin_up;
	logic [FRAC_W-1:0]       random_fraction;
	logic                    out_valid;
	logic                    out_stall;
	logic                    flipped;
	logic                    random_needed;
	logic signed [SUM_W-1:0] magnetization;
	logic                    sweep_done;

	ising_scoreboard sb = new();
	factor_t factor_plan [NUM_FACTORS];
	bit idling_on;
	int unsigned hold_left;
	int unsigned rx_burst_left;
	int unsigned cycle_count;

	metropolis_ising_plaquette_update u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.site_row        (site_row),
		.site_col        (site_col),
		.spin_up         (spin_up),
		.random_fraction (random_fraction),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.flipped         (flipped),
		.random_needed   (random_needed),
		.magnetization   (magnetization),
		.sweep_done      (sweep_done)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: a long hold when asked, otherwise random stall bursts while idling is on
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (rx_burst_left > 0) begin
			out_stall <= 1'b1;
			rx_burst_left--;
		end else if (idling_on && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			rx_burst_left = $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : result_monitor
		spin_result_t seen;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			seen.flipped = flipped;
			seen.rnd_needed = random_needed;
			seen.mag = magnetization;
			seen.done = sweep_done;
			sb.check_result(seen);
		end
	end

	task automatic write_reg(input int unsigned idx, input factor_t data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= data;
		@(posedge clk);
		sb.write_factor(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_factors();
		for (int unsigned k = 0; k < NUM_FACTORS; k++)
			write_reg(k, factor_plan[k]);
	endtask

	task automatic drive_item(input spin_item_t it);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		action <= it.act;
		site_row <= it.row;
		site_col <= it.col;
		spin_up <= it.up;
		random_fraction <= it.frac;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_item(it);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic spin_item_t load_item(input int unsigned row, input int unsigned col,
			input logic up);
		spin_item_t it;
		it.act = ACT_LOAD;
		it.row = ROW_W'(row);
		it.col = ROW_W'(col);
		it.up = up;
		it.frac = FRAC_W'($urandom);
		return it;
	endfunction

	function automatic spin_item_t update_item(input logic [FRAC_W-1:0] frac);
		spin_item_t it;
		it.act = ACT_UPDATE;
		it.row = ROW_W'($urandom);
		it.col = ROW_W'($urandom);
		it.up = 1'($urandom);
		it.frac = frac;
		return it;
	endfunction

	function automatic spin_item_t random_item();
		spin_item_t it;
		int unsigned r, c;
		logic [PROD_W-1:0] prod;
		it = update_item(FRAC_W'($urandom));
		if ($urandom_range(0, 3) == 0) begin
			it.act = ACT_LOAD;
			// half of the loads land around the site that the sweep visits next
			if ($urandom_range(0, 1) == 1) begin
				sb.site_of_pos(sb.sweep_pos, r, c);
				it.row = ROW_W'(r + SIDE + $urandom_range(0, 2) - 1);
				it.col = ROW_W'(c + SIDE + $urandom_range(0, 2) - 1);
			end
		end else begin
			prod = sb.site_product();
			case ($urandom_range(0, 7))
				0: it.frac = '0;
				1: it.frac = FRAC_MAX;
				// land on or just above the product
				2, 3: if (prod < PROD_ONE)
					it.frac = prod[2*FRAC_W-1:FRAC_W] + FRAC_W'($urandom_range(0, 1));
				default: ;
			endcase
		end
		return it;
	endfunction

	function automatic void plan_temperature();
		// about T = 2.27, plaquette coupling one half
		factor_plan[REG_PAIR_PLUS8]  = 32'h0007_8B40;
		factor_plan[REG_PAIR_PLUS4]  = 32'h002B_F4BC;
		factor_plan[REG_PAIR_MINUS4] = 32'h05D2_F1B0;
		factor_plan[REG_PAIR_MINUS8] = 32'h21EB_8500;
		factor_plan[REG_PLAQ_PLUS8]  = 32'h002B_F4BC;
		factor_plan[REG_PLAQ_PLUS4]  = 32'h006A_1440;
		factor_plan[REG_PLAQ_MINUS4] = 32'h0269_D390;
		factor_plan[REG_PLAQ_MINUS8] = 32'h05D2_F1B0;
	endfunction

	initial begin : stimulus
		int unsigned phase, n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_LOAD;
		site_row = '0;
		site_col = '0;
		spin_up = 1'b0;
		random_fraction = '0;
		out_stall = 1'b0;
		idling_on = 1'b0;
		hold_left = 0;
		rx_burst_left = 0;
		cycle_count = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// factors still at reset: every product is exactly 1.0
		drive_item(load_item(0, 0, 1'b1));
		drive_item(load_item(SIDE - 1, SIDE - 1, 1'b1));
		drive_item(load_item(0, SIDE - 1, 1'b0));
		drive_item(load_item(SIDE - 1, 0, 1'b1));
		drive_item(load_item(0, 0, 1'b0));
		drive_item(load_item(21, 42, 1'b1));
		drive_item(load_item(42, 21, 1'b1));
		drive_item(update_item(FRAC_MAX));
		drive_item(update_item('0));
		drain();

		// pair factors one half, plaquette neutral; unmapped writes must not land
		foreach (factor_plan[k])
			factor_plan[k] = (k < REG_PLAQ_PLUS8) ? (ONE_Q24 >> 1) : ONE_Q24;
		load_factors();
		write_reg(REG_UNMAPPED_LO, '0);
		write_reg(REG_UNMAPPED_HI, '0);
		drive_item(update_item(FRAC_HALF));
		drive_item(update_item(FRAC_HALF + 1'b1));
		drive_item(update_item('0));
		drive_item(update_item(FRAC_MAX));
		drive_item(load_item(0, 11, 1'b1));
		drive_item(load_item(0, 13, 1'b1));
		drive_item(update_item(FRAC_MAX));
		drive_item(update_item(FRAC_MAX));
		drive_item(update_item(FRAC_HALF));
		drain();

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: foreach (factor_plan[k]) factor_plan[k] = '0;
				1: foreach (factor_plan[k]) factor_plan[k] = '1;
				2: plan_temperature();
				default: begin
					foreach (factor_plan[k]) begin
						case ($urandom_range(0, 4))
							0: factor_plan[k] = '0;
							1: factor_plan[k] = ONE_Q24;
							2: factor_plan[k] = '1;
							3: factor_plan[k] = $urandom;
							default: factor_plan[k] = ONE_Q24 >> $urandom_range(1, 8);
						endcase
					end
					// a half and a two meet at a product of exactly 1.0
					factor_plan[REG_PAIR_PLUS4] = ONE_Q24 >> 1;
					factor_plan[REG_PLAQ_MINUS4] = ONE_Q24 << 1;
				end
			endcase
			load_factors();
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					idling_on = ($urandom_range(0, 3) != 0);
				// long receiver hold so the block backs up into its input
				if (phase == 2 && n == 20)
					hold_left = HOLD_CYCLES;
				drive_item(random_item());
			end
			drain();
		end

		// closing stretch of site updates at full rate
		idling_on = 1'b0;
		plan_temperature();
		load_factors();
		for (n = 0; n < TAIL_ITEMS; n++)
			drive_item(update_item(FRAC_W'($urandom)));
		drain();

		$display("run: %0d loads, %0d site updates, %0d flips, %0d settled by the random fraction",
			sb.loads, sb.updates, sb.flips, sb.rnd_decided);
		$display("run: %0d full sweeps, %0d results compared, %0d errors",
			sb.sweeps, sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/mip_pkg.sv
hw/rtl/mip_ram.sv
hw/rtl/mip_accept.sv
hw/rtl/metropolis_ising_plaquette_update.sv
hw/rtl/mip_checker.sv
dv/metropolis_ising_plaquette_update_tb.sv
